// ===== rtl/core/cpcr_pkg.sv =====
// shared constants for the circle pair collision response pipeline
package cpcr_pkg;

    // fraction bits of the internal unit normal
    localparam int NORM_BITS = 24;

    // pipeline stages ahead of the square root
    localparam int FRONT_STAGES = 4;

    // pipeline stages after the divider, output register included
    localparam int RESP_STAGES = 5;

endpackage

// ===== rtl/core/cpcr_isqrt.sv =====
// pipelined integer square root, one result bit per register stage
module cpcr_isqrt #(
    parameter int XW = 51,
    parameter int RW = 25,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [XW-1:0] x,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [RW-1:0] root,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [RW];
    logic [XW-1:0] x_reg    [RW];
    logic [XW-1:0] sq_reg   [RW];
    logic [RW-1:0] r_reg    [RW];
    logic [SW-1:0] side_reg [RW];

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_stage
            localparam int B = RW - 1 - i;
            logic          v_in;
            logic [XW-1:0] x_in;
            logic [XW-1:0] sq_in;
            logic [RW-1:0] r_in;
            logic [SW-1:0] s_in;
            logic [XW:0]   trial;
            logic [XW-1:0] sq_next;
            logic [RW-1:0] r_next;

            if (i == 0)
            begin : g_first
                assign v_in  = in_vld;
                assign x_in  = x;
                assign sq_in = '0;
                assign r_in  = '0;
                assign s_in  = in_side;
            end
            else
            begin : g_rest
                assign v_in  = vld_reg[i-1];
                assign x_in  = x_reg[i-1];
                assign sq_in = sq_reg[i-1];
                assign r_in  = r_reg[i-1];
                assign s_in  = side_reg[i-1];
            end

            // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
            always_comb
            begin
                trial = {1'b0, sq_in} + ((XW+1)'(r_in) << (B + 1))
                        + ((XW+1)'(1) << (2 * B));
                if (trial <= {1'b0, x_in})
                begin
                    sq_next = trial[XW-1:0];
                    r_next  = r_in | (RW'(1) << B);
                end
                else
                begin
                    sq_next = sq_in;
                    r_next  = r_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en)
                    vld_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i]    <= x_in;
                    sq_reg[i]   <= sq_next;
                    r_reg[i]    <= r_next;
                    side_reg[i] <= s_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[RW-1];
    assign root     = r_reg[RW-1];
    assign out_side = side_reg[RW-1];

endmodule

// ===== rtl/core/cpcr_ndiv.sv =====
// pipelined rounded divider, two numerators over one shared denominator
module cpcr_ndiv #(
    parameter int DW = 25,
    parameter int MW = 25,
    parameter int SW = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [DW-1:0]               den,
    input  logic [MW-1:0]               mx,
    input  logic [MW-1:0]               my,
    input  logic [SW-1:0]               in_side,
    output logic                        out_vld,
    output logic [cpcr_pkg::NORM_BITS:0] qx,
    output logic [cpcr_pkg::NORM_BITS:0] qy,
    output logic [SW-1:0]               out_side
);

    localparam int QW = cpcr_pkg::NORM_BITS + 1;
    localparam int NW = MW + cpcr_pkg::NORM_BITS;

    logic          vld_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [NW-1:0] nx_reg   [QW];
    logic [NW-1:0] ny_reg   [QW];
    logic [DW-1:0] rx_reg   [QW];
    logic [DW-1:0] ry_reg   [QW];
    logic [QW-1:0] qx_reg   [QW];
    logic [QW-1:0] qy_reg   [QW];
    logic [SW-1:0] side_reg [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            localparam int B = QW - 1 - i;
            logic          v_in;
            logic [DW-1:0] d_in;
            logic [NW-1:0] nx_in;
            logic [NW-1:0] ny_in;
            logic [DW-1:0] rx_in;
            logic [DW-1:0] ry_in;
            logic [QW-1:0] qx_in;
            logic [QW-1:0] qy_in;
            logic [SW-1:0] s_in;
            logic [DW:0]   tx;
            logic [DW:0]   ty;
            logic [DW-1:0] rx_next;
            logic [DW-1:0] ry_next;
            logic [QW-1:0] qx_next;
            logic [QW-1:0] qy_next;

            if (i == 0)
            begin : g_first
                // numerator with half the divisor added for rounding
                assign nx_in = (NW'(mx) << cpcr_pkg::NORM_BITS) + NW'(den >> 1);
                assign ny_in = (NW'(my) << cpcr_pkg::NORM_BITS) + NW'(den >> 1);
                assign v_in  = in_vld;
                assign d_in  = den;
                assign rx_in = DW'(nx_in >> QW);
                assign ry_in = DW'(ny_in >> QW);
                assign qx_in = '0;
                assign qy_in = '0;
                assign s_in  = in_side;
            end
            else
            begin : g_rest
                assign v_in  = vld_reg[i-1];
                assign d_in  = den_reg[i-1];
                assign nx_in = nx_reg[i-1];
                assign ny_in = ny_reg[i-1];
                assign rx_in = rx_reg[i-1];
                assign ry_in = ry_reg[i-1];
                assign qx_in = qx_reg[i-1];
                assign qy_in = qy_reg[i-1];
                assign s_in  = side_reg[i-1];
            end

            // one restoring step per quotient bit
            always_comb
            begin
                tx = {rx_in, nx_in[B]};
                ty = {ry_in, ny_in[B]};
                if (tx >= {1'b0, d_in})
                begin
                    rx_next = DW'(tx - {1'b0, d_in});
                    qx_next = qx_in | (QW'(1) << B);
                end
                else
                begin
                    rx_next = tx[DW-1:0];
                    qx_next = qx_in;
                end
                if (ty >= {1'b0, d_in})
                begin
                    ry_next = DW'(ty - {1'b0, d_in});
                    qy_next = qy_in | (QW'(1) << B);
                end
                else
                begin
                    ry_next = ty[DW-1:0];
                    qy_next = qy_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en)
                    vld_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[i]  <= d_in;
                    nx_reg[i]   <= nx_in;
                    ny_reg[i]   <= ny_in;
                    rx_reg[i]   <= rx_next;
                    ry_reg[i]   <= ry_next;
                    qx_reg[i]   <= qx_next;
                    qy_reg[i]   <= qy_next;
                    side_reg[i] <= s_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QW-1];
    assign qx       = qx_reg[QW-1];
    assign qy       = qy_reg[QW-1];
    assign out_side = side_reg[QW-1];

endmodule

// ===== rtl/core/cpcr_resp.sv =====
// response stages: normal velocity, velocity exchange, push apart, saturation
module cpcr_resp #(
    parameter int W = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [cpcr_pkg::NORM_BITS:0] qx,
    input  logic [cpcr_pkg::NORM_BITS:0] qy,
    input  logic                         neg_x,
    input  logic                         neg_y,
    input  logic                         hit_in,
    input  logic [W:0]                   dist_in,
    input  logic [W-1:0]                 sum,
    input  logic signed [W-1:0]          pay [8],
    output logic                         out_vld,
    output logic signed [W-1:0]          res [8],
    output logic                         hit
);

    localparam int NB   = cpcr_pkg::NORM_BITS;
    localparam int NNW  = NB + 2;
    localparam int VW   = W + 1;
    localparam int OVW  = W + 2;
    localparam int PW   = VW + NNW;
    localparam int VNW  = PW + 1;
    localparam int VFW  = VNW - NB + 1;
    localparam int MDW  = VFW + NNW;
    localparam int DVW  = MDW - NB + 1;
    localparam int MPW  = OVW + NNW;
    localparam int PXW  = MPW - NB;
    localparam int EW   = DVW + 2;
    localparam longint SMAXL = (longint'(1) <<< (W - 1)) - 1;
    localparam logic signed [EW-1:0] SMAX = EW'(SMAXL);
    localparam logic signed [EW-1:0] SMIN = -SMAX - EW'(1);

    // stage 1: signed normal, relative velocity, overlap
    logic                   v1_reg, h1_reg;
    logic signed [NNW-1:0]  nx1_reg, ny1_reg;
    logic signed [VW-1:0]   rvx1_reg, rvy1_reg;
    logic signed [OVW-1:0]  ov1_reg;
    logic signed [W-1:0]    p1_reg [8];

    // stage 2: dot products
    logic                   v2_reg, h2_reg;
    logic signed [NNW-1:0]  nx2_reg, ny2_reg;
    logic signed [PW-1:0]   dpx2_reg, dpy2_reg;
    logic signed [OVW-1:0]  ov2_reg;
    logic signed [W-1:0]    p2_reg [8];

    // stage 3: rounded normal speed, separating test
    logic                   v3_reg, h3_reg;
    logic signed [NNW-1:0]  nx3_reg, ny3_reg;
    logic signed [VFW-1:0]  vnf3_reg;
    logic signed [OVW-1:0]  ov3_reg;
    logic signed [W-1:0]    p3_reg [8];
    logic signed [VNW-1:0]  vn;
    logic [VNW-1:0]         vn_mag;
    logic [VNW-1:0]         vn_rnd;
    logic signed [VFW-1:0]  vnf_next;
    logic                   h3_next;

    // stage 4: velocity change and push products
    logic                   v4_reg, h4_reg;
    logic signed [MDW-1:0]  mdx4_reg, mdy4_reg;
    logic signed [MPW-1:0]  mpx4_reg, mpy4_reg;
    logic signed [W-1:0]    p4_reg [8];

    // stage 5: output register
    logic                   v5_reg, h5_reg;
    logic signed [W-1:0]    r5_reg [8];
    logic signed [W-1:0]    r5_next [8];
    logic [MDW-1:0]         mdx_mag, mdy_mag;
    logic [MPW-1:0]         mpx_mag, mpy_mag;
    logic signed [DVW-1:0]  dvx, dvy;
    logic signed [PXW-1:0]  px, py;
    logic signed [EW-1:0]   wide [8];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg   <= hit_in;
            nx1_reg  <= neg_x ? -NNW'(qx) : NNW'(qx);
            ny1_reg  <= neg_y ? -NNW'(qy) : NNW'(qy);
            rvx1_reg <= VW'(pay[6]) - VW'(pay[2]);
            rvy1_reg <= VW'(pay[7]) - VW'(pay[3]);
            ov1_reg  <= OVW'(sum) - OVW'(dist_in);
            p1_reg   <= pay;
        end
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h2_reg   <= h1_reg;
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            dpx2_reg <= PW'(rvx1_reg) * PW'(nx1_reg);
            dpy2_reg <= PW'(rvy1_reg) * PW'(ny1_reg);
            ov2_reg  <= ov1_reg;
            p2_reg   <= p1_reg;
        end
    end

    // stage 3 logic: sum, round half away from zero
    always_comb
    begin
        vn       = VNW'(dpx2_reg) + VNW'(dpy2_reg);
        vn_mag   = vn[VNW-1] ? VNW'(-vn) : VNW'(vn);
        vn_rnd   = (vn_mag + (VNW'(1) << (NB - 1))) >> NB;
        vnf_next = vn[VNW-1] ? -VFW'(vn_rnd) : VFW'(vn_rnd);
        h3_next  = h2_reg && !(vn > 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h3_reg   <= h3_next;
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            vnf3_reg <= vnf_next;
            ov3_reg  <= ov2_reg;
            p3_reg   <= p2_reg;
        end
    end

    // stage 4
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h4_reg   <= h3_reg;
            mdx4_reg <= MDW'(vnf3_reg) * MDW'(nx3_reg);
            mdy4_reg <= MDW'(vnf3_reg) * MDW'(ny3_reg);
            mpx4_reg <= MPW'(ov3_reg) * MPW'(nx3_reg);
            mpy4_reg <= MPW'(ov3_reg) * MPW'(ny3_reg);
            p4_reg   <= p3_reg;
        end
    end

    // stage 5 logic: round, apply, saturate; a miss passes the payload through
    always_comb
    begin
        mdx_mag = mdx4_reg[MDW-1] ? MDW'(-mdx4_reg) : MDW'(mdx4_reg);
        mdy_mag = mdy4_reg[MDW-1] ? MDW'(-mdy4_reg) : MDW'(mdy4_reg);
        mpx_mag = mpx4_reg[MPW-1] ? MPW'(-mpx4_reg) : MPW'(mpx4_reg);
        mpy_mag = mpy4_reg[MPW-1] ? MPW'(-mpy4_reg) : MPW'(mpy4_reg);
        mdx_mag = (mdx_mag + (MDW'(1) << (NB - 1))) >> NB;
        mdy_mag = (mdy_mag + (MDW'(1) << (NB - 1))) >> NB;
        mpx_mag = (mpx_mag + (MPW'(1) << NB)) >> (NB + 1);
        mpy_mag = (mpy_mag + (MPW'(1) << NB)) >> (NB + 1);
        dvx = mdx4_reg[MDW-1] ? -DVW'(mdx_mag) : DVW'(mdx_mag);
        dvy = mdy4_reg[MDW-1] ? -DVW'(mdy_mag) : DVW'(mdy_mag);
        px  = mpx4_reg[MPW-1] ? -PXW'(mpx_mag) : PXW'(mpx_mag);
        py  = mpy4_reg[MPW-1] ? -PXW'(mpy_mag) : PXW'(mpy_mag);
        wide[0] = EW'(p4_reg[0]) - EW'(px);
        wide[1] = EW'(p4_reg[1]) - EW'(py);
        wide[2] = EW'(p4_reg[2]) + EW'(dvx);
        wide[3] = EW'(p4_reg[3]) + EW'(dvy);
        wide[4] = EW'(p4_reg[4]) + EW'(px);
        wide[5] = EW'(p4_reg[5]) + EW'(py);
        wide[6] = EW'(p4_reg[6]) - EW'(dvx);
        wide[7] = EW'(p4_reg[7]) - EW'(dvy);
        for (int k = 0; k < 8; k++)
        begin
            if (!h4_reg)
                r5_next[k] = p4_reg[k];
            else if (wide[k] > SMAX)
                r5_next[k] = W'(SMAX);
            else if (wide[k] < SMIN)
                r5_next[k] = W'(SMIN);
            else
                r5_next[k] = W'(wide[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h5_reg <= h4_reg;
            r5_reg <= r5_next;
        end
    end

    assign out_vld = v5_reg;
    assign res     = r5_reg;
    assign hit     = h5_reg;

endmodule

// ===== rtl/core/circle_pair_collision_response.sv =====
// top level of the circle pair collision response pipeline
// throughput: one item per cycle while the output is not stalled, set by a fully pipelined square root and divider
// a stalled output freezes every stage; nothing is dropped or repeated
// reset clears all valid bits asynchronously; data registers are not reset
module circle_pair_collision_response #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] first_pos_x,
    input  logic signed [COORD_WIDTH-1:0] first_pos_y,
    input  logic signed [COORD_WIDTH-1:0] first_vel_x,
    input  logic signed [COORD_WIDTH-1:0] first_vel_y,
    input  logic [COORD_WIDTH-2:0]        first_radius,
    input  logic signed [COORD_WIDTH-1:0] second_pos_x,
    input  logic signed [COORD_WIDTH-1:0] second_pos_y,
    input  logic signed [COORD_WIDTH-1:0] second_vel_x,
    input  logic signed [COORD_WIDTH-1:0] second_vel_y,
    input  logic [COORD_WIDTH-2:0]        second_radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] new_first_pos_x,
    output logic signed [COORD_WIDTH-1:0] new_first_pos_y,
    output logic signed [COORD_WIDTH-1:0] new_first_vel_x,
    output logic signed [COORD_WIDTH-1:0] new_first_vel_y,
    output logic signed [COORD_WIDTH-1:0] new_second_pos_x,
    output logic signed [COORD_WIDTH-1:0] new_second_pos_y,
    output logic signed [COORD_WIDTH-1:0] new_second_vel_x,
    output logic signed [COORD_WIDTH-1:0] new_second_vel_y,
    output logic                          hit
);

    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 1;
    localparam int AW  = W + 1;
    localparam int SQW = 2 * AW + 1;
    localparam int PFW = 8 * W;
    localparam int S1W = 3 + 2 * AW + W + PFW;
    localparam int S2W = 3 + AW + W + PFW;

    logic en;

    // stage 1: center difference, radius sum
    logic                 v1_reg;
    logic signed [VW-1:0] dx1_reg, dy1_reg;
    logic [W-1:0]         sum1_reg;
    logic signed [W-1:0]  p1_reg [8];

    // stage 2: magnitudes and signs
    logic                 v2_reg;
    logic [AW-1:0]        ax2_reg, ay2_reg;
    logic                 sx2_reg, sy2_reg;
    logic [W-1:0]         sum2_reg;
    logic signed [W-1:0]  p2_reg [8];

    // stage 3: squares
    logic                 v3_reg;
    logic [2*AW-1:0]      sqx3_reg, sqy3_reg;
    logic [2*W-1:0]       rr3_reg;
    logic [AW-1:0]        ax3_reg, ay3_reg;
    logic                 sx3_reg, sy3_reg;
    logic [W-1:0]         sum3_reg;
    logic signed [W-1:0]  p3_reg [8];

    // stage 4: squared distance and touch test
    logic                 v4_reg;
    logic [SQW-1:0]       s4_reg;
    logic                 t4_reg;
    logic [AW-1:0]        ax4_reg, ay4_reg;
    logic                 sx4_reg, sy4_reg;
    logic [W-1:0]         sum4_reg;
    logic signed [W-1:0]  p4_reg [8];
    logic [SQW-1:0]       s_next;

    logic [PFW-1:0]       pf4;
    logic [S1W-1:0]       side1_in, side1_out;
    logic                 sq_vld;
    logic [AW-1:0]        root;
    logic [S2W-1:0]       side2_in, side2_out;
    logic                 dv_vld;
    logic [cpcr_pkg::NORM_BITS:0] qx, qy;
    logic signed [W-1:0]  pay_d [8];
    logic signed [W-1:0]  res [8];
    logic                 resp_vld;

    // whole pipeline moves unless a finished item is held at the output
    assign en       = !resp_vld || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg   <= VW'(second_pos_x) - VW'(first_pos_x);
            dy1_reg   <= VW'(second_pos_y) - VW'(first_pos_y);
            sum1_reg  <= W'(first_radius) + W'(second_radius);
            p1_reg[0] <= first_pos_x;
            p1_reg[1] <= first_pos_y;
            p1_reg[2] <= first_vel_x;
            p1_reg[3] <= first_vel_y;
            p1_reg[4] <= second_pos_x;
            p1_reg[5] <= second_pos_y;
            p1_reg[6] <= second_vel_x;
            p1_reg[7] <= second_vel_y;
        end
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax2_reg  <= dx1_reg[VW-1] ? AW'(-dx1_reg) : AW'(dx1_reg);
            ay2_reg  <= dy1_reg[VW-1] ? AW'(-dy1_reg) : AW'(dy1_reg);
            sx2_reg  <= dx1_reg[VW-1];
            sy2_reg  <= dy1_reg[VW-1];
            sum2_reg <= sum1_reg;
            p2_reg   <= p1_reg;
        end
    end

    // stage 3
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx3_reg <= (2*AW)'(ax2_reg) * (2*AW)'(ax2_reg);
            sqy3_reg <= (2*AW)'(ay2_reg) * (2*AW)'(ay2_reg);
            rr3_reg  <= (2*W)'(sum2_reg) * (2*W)'(sum2_reg);
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;
            sum3_reg <= sum2_reg;
            p3_reg   <= p2_reg;
        end
    end

    // stage 4
    assign s_next = SQW'(sqx3_reg) + SQW'(sqy3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg   <= s_next;
            t4_reg   <= (s_next != '0) && (s_next <= SQW'(rr3_reg));
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            sx4_reg  <= sx3_reg;
            sy4_reg  <= sy3_reg;
            sum4_reg <= sum3_reg;
            p4_reg   <= p3_reg;
        end
    end

    // pack side data for the square root
    always_comb
    begin
        for (int k = 0; k < 8; k++)
            pf4[k*W +: W] = p4_reg[k];
    end

    assign side1_in = {t4_reg, sx4_reg, sy4_reg, ax4_reg, ay4_reg, sum4_reg, pf4};

    cpcr_isqrt #(
        .XW (SQW),
        .RW (AW),
        .SW (S1W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v4_reg),
        .x        (s4_reg),
        .in_side  (side1_in),
        .out_vld  (sq_vld),
        .root     (root),
        .out_side (side1_out)
    );

    // distance joins the side data; magnitudes go to the divider
    assign side2_in = {side1_out[S1W-1 -: 3], root, side1_out[W+PFW-1:0]};

    cpcr_ndiv #(
        .DW (AW),
        .MW (AW),
        .SW (S2W)
    ) u_ndiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld),
        .den      (root),
        .mx       (side1_out[W+PFW+2*AW-1 -: AW]),
        .my       (side1_out[W+PFW+AW-1 -: AW]),
        .in_side  (side2_in),
        .out_vld  (dv_vld),
        .qx       (qx),
        .qy       (qy),
        .out_side (side2_out)
    );

    always_comb
    begin
        for (int k = 0; k < 8; k++)
            pay_d[k] = side2_out[k*W +: W];
    end

    cpcr_resp #(
        .W (W)
    ) u_resp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (dv_vld),
        .qx      (qx),
        .qy      (qy),
        .neg_x   (side2_out[S2W-2]),
        .neg_y   (side2_out[S2W-3]),
        .hit_in  (side2_out[S2W-1]),
        .dist_in (side2_out[W+PFW+AW-1 -: AW]),
        .sum     (side2_out[W+PFW-1 -: W]),
        .pay     (pay_d),
        .out_vld (resp_vld),
        .res     (res),
        .hit     (hit)
    );

    assign out_valid        = resp_vld;
    assign new_first_pos_x  = res[0];
    assign new_first_pos_y  = res[1];
    assign new_first_vel_x  = res[2];
    assign new_first_vel_y  = res[3];
    assign new_second_pos_x = res[4];
    assign new_second_pos_y = res[5];
    assign new_second_vel_x = res[6];
    assign new_second_vel_y = res[7];

endmodule

// ===== rtl/core/cpcr_checker.sv =====
// port checks for the circle pair collision response and their bind
module cpcr_checker #(
    parameter int W = 24
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic signed [W-1:0] first_pos_x,
    input logic signed [W-1:0] first_pos_y,
    input logic signed [W-1:0] first_vel_x,
    input logic signed [W-1:0] first_vel_y,
    input logic [W-2:0]        first_radius,
    input logic signed [W-1:0] second_pos_x,
    input logic signed [W-1:0] second_pos_y,
    input logic signed [W-1:0] second_vel_x,
    input logic signed [W-1:0] second_vel_y,
    input logic [W-2:0]        second_radius,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [W-1:0] new_first_pos_x,
    input logic signed [W-1:0] new_first_pos_y,
    input logic signed [W-1:0] new_first_vel_x,
    input logic signed [W-1:0] new_first_vel_y,
    input logic signed [W-1:0] new_second_pos_x,
    input logic signed [W-1:0] new_second_pos_y,
    input logic signed [W-1:0] new_second_vel_x,
    input logic signed [W-1:0] new_second_vel_y,
    input logic                hit
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its values
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(new_first_pos_x) && $stable(new_first_pos_y)
            && $stable(new_first_vel_x) && $stable(new_first_vel_y)
            && $stable(new_second_pos_x) && $stable(new_second_pos_y)
            && $stable(new_second_vel_x) && $stable(new_second_vel_y) && $stable(hit))
        else $error("result changed while stalled");

    // input side only backs off when the output is blocked
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a blocked output stalls the input side
    a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output blocked");

endmodule

bind circle_pair_collision_response cpcr_checker #(.W(COORD_WIDTH)) u_cpcr_checker (.*);

// ===== sim/circle_pair_collision_response_tb.sv =====
// testbench for the circle pair collision response pipeline
`timescale 1ns / 1ps

module circle_pair_collision_response_tb;

    localparam int CW = 24;
    localparam int NB = 24;
    localparam int LATENCY = CW + 35;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] p1x, p1y, v1x, v1y;
        logic [CW-2:0]        r1;
        logic signed [CW-1:0] p2x, p2y, v2x, v2y;
        logic [CW-2:0]        r2;
    } pair_t;

    typedef struct packed {
        logic signed [CW-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        logic                 hit;
    } resp_t;

    localparam int PAIR_W = $bits(pair_t);

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    pair_t drv;
    resp_t got;

    resp_t expected_resp[$];
    int errors;
    int idle_cycles;
    bit stall_on;     // random receiver stalls enabled
    bit send_gaps;    // random sender gaps enabled
    bit hold_off;     // receiver held off by the pressure process

    circle_pair_collision_response #(.COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_pos_x(drv.p1x), .first_pos_y(drv.p1y),
        .first_vel_x(drv.v1x), .first_vel_y(drv.v1y), .first_radius(drv.r1),
        .second_pos_x(drv.p2x), .second_pos_y(drv.p2y),
        .second_vel_x(drv.v2x), .second_vel_y(drv.v2y), .second_radius(drv.r2),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_first_pos_x(got.p1x), .new_first_pos_y(got.p1y),
        .new_first_vel_x(got.v1x), .new_first_vel_y(got.v1y),
        .new_second_pos_x(got.p2x), .new_second_pos_y(got.p2y),
        .new_second_vel_x(got.v2x), .new_second_vel_y(got.v2y),
        .hit(got.hit)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [CW-1:0] clamp(input longint v);
        if (v > longint'(CMAX))
            return CMAX;
        if (v < longint'(CMIN))
            return CMIN;
        return v[CW-1:0];
    endfunction

    // round half away from zero on a right shift
    function automatic longint shift_round(input longint v, input int s);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint div_round(input longint num, input longint den);
        longint m;
        m = num < 0 ? -num : num;
        m = (m + den / 2) / den;
        return num < 0 ? -m : m;
    endfunction

    function automatic longint floor_sqrt(input longint x);
        longint r, c;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (longint'(1) << b);
            if (c * c <= x)
                r = c;
        end
        return r;
    endfunction

    // predicted response of one circle pair
    function automatic resp_t collide(input pair_t a);
        longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        longint dx, dy, s, rsum, cdist, nx, ny, vn, vnf, dvx, dvy, ov, px, py;
        logic h;
        resp_t r;
        p1x = a.p1x; p1y = a.p1y; v1x = a.v1x; v1y = a.v1y;
        p2x = a.p2x; p2y = a.p2y; v2x = a.v2x; v2y = a.v2y;
        dx = p2x - p1x;
        dy = p2y - p1y;
        s = dx * dx + dy * dy;
        rsum = longint'(a.r1) + longint'(a.r2);
        h = (s != 0) && (s <= rsum * rsum);
        if (h)
        begin
            cdist = floor_sqrt(s);
            nx = div_round(dx * (longint'(1) << NB), cdist);
            ny = div_round(dy * (longint'(1) << NB), cdist);
            vn = (v2x - v1x) * nx + (v2y - v1y) * ny;
            if (vn > 0)
                h = 1'b0;
            else
            begin
                vnf = shift_round(vn, NB);
                dvx = shift_round(vnf * nx, NB);
                dvy = shift_round(vnf * ny, NB);
                ov = rsum - cdist;
                px = shift_round(ov * nx, NB + 1);
                py = shift_round(ov * ny, NB + 1);
                v1x += dvx; v1y += dvy; v2x -= dvx; v2y -= dvy;
                p1x -= px; p1y -= py; p2x += px; p2y += py;
            end
        end
        r.p1x = clamp(p1x); r.p1y = clamp(p1y); r.v1x = clamp(v1x); r.v1y = clamp(v1y);
        r.p2x = clamp(p2x); r.p2y = clamp(p2y); r.v2x = clamp(v2x); r.v2y = clamp(v2y);
        r.hit = h;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint g, input longint e);
        $display("mismatch %s: got %0d expected %0d at %0t", what, g, e, $realtime);
        errors++;
    endtask

    // send one item, with an optional random gap ahead of it
    task automatic send_pair(input pair_t a);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        drv <= a;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_resp.push_back(collide(a));
        @(negedge clk);
    endtask

    // drop valid and wait for the next falling edge before anything new is offered
    task automatic end_burst();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_resp.size() != 0)
            @(negedge clk);
    endtask

    // check each result against the oldest prediction
    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_resp.size() == 0)
            begin
                $display("unexpected item at %0t", $realtime);
                errors++;
            end
            else
            begin
                e = expected_resp.pop_front();
                if (got.p1x !== e.p1x) report_mismatch("first_pos_x", got.p1x, e.p1x);
                if (got.p1y !== e.p1y) report_mismatch("first_pos_y", got.p1y, e.p1y);
                if (got.v1x !== e.v1x) report_mismatch("first_vel_x", got.v1x, e.v1x);
                if (got.v1y !== e.v1y) report_mismatch("first_vel_y", got.v1y, e.v1y);
                if (got.p2x !== e.p2x) report_mismatch("second_pos_x", got.p2x, e.p2x);
                if (got.p2y !== e.p2y) report_mismatch("second_pos_y", got.p2y, e.p2y);
                if (got.v2x !== e.v2x) report_mismatch("second_vel_x", got.v2x, e.v2x);
                if (got.v2y !== e.v2y) report_mismatch("second_vel_y", got.v2y, e.v2y);
                if (got.hit !== e.hit) report_mismatch("hit", got.hit, e.hit);
            end
        end
    end

    // receiver readiness: random stall bursts and the long hold-off
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 16);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $realtime);
            $display("circle_pair_collision_response_tb: done, errors");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rnd_coord();
        return CW'($urandom);
    endfunction

    // a pair with close centers that may touch, with random velocities
    function automatic pair_t touching_pair(input int span);
        pair_t a;
        int dx, dy;
        a.p1x = rnd_coord() >>> 2;
        a.p1y = rnd_coord() >>> 2;
        dx = $urandom_range(0, 2 * span) - span;
        dy = $urandom_range(0, 2 * span) - span;
        a.p2x = a.p1x + CW'(dx);
        a.p2y = a.p1y + CW'(dy);
        a.r1 = (CW-1)'($urandom_range(1, span));
        a.r2 = (CW-1)'($urandom_range(span / 2, span));
        a.v1x = rnd_coord() >>> $urandom_range(0, 12);
        a.v1y = rnd_coord() >>> $urandom_range(0, 12);
        a.v2x = rnd_coord() >>> $urandom_range(0, 12);
        a.v2y = rnd_coord() >>> $urandom_range(0, 12);
        return a;
    endfunction

    function automatic pair_t noise_pair();
        pair_t a;
        a = PAIR_W'({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
        return a;
    endfunction

    // extremes of the fields and each special case
    task automatic test_directed();
        pair_t a;
        a = '0;
        send_pair(a);                           // coincident centers
        a = '0; a.p2x = 100; a.r1 = 10; a.r2 = 10;
        send_pair(a);                           // separated
        a.r1 = 50; a.r2 = 50;
        a.v1x = 300;
        send_pair(a);                           // approaching head on
        a.v1x = -300;
        send_pair(a);                           // separating
        a.v1x = 0;
        send_pair(a);                           // zero normal velocity
        a.p2x = 100; a.p2y = 0; a.r1 = 50; a.r2 = 50; a.v1x = 0;
        send_pair(a);                           // just touching
        a = '0; a.p1x = CMAX; a.p2x = CMIN; a.r1 = '1; a.r2 = '1;
        send_pair(a);                           // extreme span
        a = '0; a.p1x = CMAX; a.p2x = CMAX - CW'(1); a.r1 = '1; a.r2 = '1;
        a.v1x = CMIN; a.v2x = CMAX;
        send_pair(a);                           // saturated positions
        a.p1x = 0; a.p2x = 1; a.v1x = CMAX; a.v2x = CMIN;
        send_pair(a);                           // saturated velocities
        a = '0; a.p1x = CMIN; a.p1y = CMIN; a.p2x = CMAX; a.p2y = CMAX;
        a.v1x = CMAX; a.v1y = CMAX; a.v2x = CMIN; a.v2y = CMIN; a.r1 = '1; a.r2 = '1;
        send_pair(a);                           // largest diagonal
        a = '0; a.p2y = -3; a.r1 = 2; a.r2 = 2; a.v1y = -7; a.v2y = 9;
        send_pair(a);
        a = '1; a.p2x = CMAX; send_pair(a);
        end_burst();
        wait_drained();
    endtask

    // random pairs, mostly close pairs that may touch
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_pair(noise_pair());
                2: send_pair(touching_pair(8));
                3: send_pair(touching_pair(1 << 20));
                default: send_pair(touching_pair($urandom_range(16, 1 << 14)));
            endcase
        end
        end_burst();
    endtask

    // receiver held off while items keep coming, to fill the pipeline
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (LATENCY * 3) @(negedge clk);
                hold_off = 1'b0;
            end
            test_random(LATENCY * 2);
        join
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        stall_on = 1'b0;
        send_gaps = 1'b0;
        hold_off = 1'b0;
        in_valid = 1'b0;
        drv = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        stall_on = 1'b1;
        send_gaps = 1'b1;
        test_random(300);
        wait_drained();            // sender pauses until all results are in
        test_backpressure();
        test_random(250);
        stall_on = 1'b0;
        send_gaps = 1'b0;
        test_random(100);
        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);

        if (errors == 0)
            $display("circle_pair_collision_response_tb: done, clean");
        else
            $display("circle_pair_collision_response_tb: done, errors");
        $finish;
    end

endmodule
